/* hdl/i2d_pkg.sv */
`timescale 1ns / 1ps
package i2d_pkg;

   localparam int DEFAULT_VALUE_BITS = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Decimal digits needed for 2**bits - 1; 1233/4096 approximates log10(2).
   function automatic int dec_digits(input int bits);
      dec_digits = ((bits * 1233) >> 12) + 1;
   endfunction

   // Commands from the sequencer to the digit shift register.
   typedef struct packed {
      logic load;        // take a new magnitude, clear the BCD digits
      logic bit_step;    // one double-dabble step: adjust digits, shift in one bit
      logic digit_step;  // shift the BCD digits up by one decimal digit
   } i2d_ctl_type;

endpackage

/* hdl/i2d_dabble.sv */
`timescale 1ns / 1ps
module i2d_dabble #(
   parameter int VALUE_BITS = 64,
   parameter int DIGITS     = 20
) (
   input  logic                    clock,
   input  i2d_pkg::i2d_ctl_type    ctl,
   input  logic [VALUE_BITS-1:0]   load_mag,
   output logic [3:0]              top_digit
);
   import i2d_pkg::*;

   localparam int BCD_BITS = 4 * DIGITS;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;

   // Add 3 to every digit of 5 or more before the shift.
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         mag_in = load_mag;
         bcd_in = '0;
      end else if (ctl.bit_step) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
      end else if (ctl.digit_step) begin
         bcd_in = {bcd_ff[BCD_BITS-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

endmodule

/* hdl/i2d_seq.sv */
`timescale 1ns / 1ps
module i2d_seq #(
   parameter int VALUE_BITS = 64,
   parameter int DIGITS     = 20
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [63:0]             req_value,
   input  logic                    req_is_signed,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_char_code,
   output logic                    rsp_last,
   output i2d_pkg::i2d_ctl_type    ctl,
   output logic [VALUE_BITS-1:0]   load_mag,
   input  logic [3:0]              top_digit
);
   import i2d_pkg::*;

   localparam int CW = $clog2(VALUE_BITS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  accept;
   logic [VALUE_BITS-1:0] raw;
   logic                  raw_neg;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign raw      = req_value[VALUE_BITS-1:0];
   assign raw_neg  = req_is_signed && raw[VALUE_BITS-1];
   assign load_mag = raw_neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ctl            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.load = 1'b1;
               neg_in   = raw_neg;
               cnt_in   = CW'(VALUE_BITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.bit_step = 1'b1;
            cnt_in       = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               cnt_in   = CW'(DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && cnt_ff != CW'(1)) begin
               ctl.digit_step = 1'b1;
               cnt_in         = cnt_ff - CW'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_char_in    = CHAR_ZERO + {4'd0, top_digit};
               rsp_last_in    = (cnt_ff == CW'(1));
               ctl.digit_step = 1'b1;
               cnt_in         = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* hdl/int64_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
// Converts a VALUE_BITS-wide integer (read as signed or unsigned per transaction)
// to decimal ASCII, one character per response transaction, most significant
// digit first, with no leading zeros and a leading '-' for negative signed
// values; rsp_last marks the final character. Conversion is bit-serial double
// dabble: the BCD digits are built one magnitude bit at a time, then leading
// zeros are dropped one digit at a time, then the characters (sign included)
// are emitted as the output register frees up. req_ready rises again once the
// final character is loaded into the output register, so that character may
// still sit in the output register while the next request is accepted.
module int64_to_decimal_ascii_core #(
   parameter int VALUE_BITS = i2d_pkg::DEFAULT_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic        req_is_signed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);
   import i2d_pkg::*;

   localparam int DIGITS = dec_digits(VALUE_BITS);

   i2d_ctl_type           ctl;
   logic [VALUE_BITS-1:0] load_mag;
   logic [3:0]            top_digit;

   i2d_seq #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .ctl           (ctl),
      .load_mag      (load_mag),
      .top_digit     (top_digit)
   );

   i2d_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctl       (ctl),
      .load_mag  (load_mag),
      .top_digit (top_digit)
   );

endmodule
